>>> sv/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

	// Sextet codes above the alphabet
	localparam logic [6:0] SYM_PAD = 7'd64;
	localparam logic [6:0] SYM_BAD = 7'd65;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,	// also "no error" in the error register
		ST_DONE    = 2'd1,
		ST_BADCHAR = 2'd2,
		ST_BADLEN  = 2'd3
	} status_t;

	// Results caused by one item: cnt of them (0..3), bytes[0] goes out first
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		status_t         status;
	} group_t;

	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [7:0] diff_upper;
		logic [7:0] diff_lower;
		logic [7:0] diff_digit;
		logic [6:0] sym;
		diff_upper = c - 8'h41;
		diff_lower = c - 8'h61;
		diff_digit = c - 8'h30;
		priority if (c >= 8'h41 && c <= 8'h5a) begin
			sym = diff_upper[6:0];
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			sym = 7'd26 + diff_lower[6:0];
		end else if (c >= 8'h30 && c <= 8'h39) begin
			sym = 7'd52 + diff_digit[6:0];
		end else if (c == 8'h2b) begin
			sym = 7'd62;
		end else if (c == 8'h2f) begin
			sym = 7'd63;
		end else if (c == 8'h3d) begin
			sym = SYM_PAD;
		end else begin
			sym = SYM_BAD;
		end
		return sym;
	endfunction

endpackage
`default_nettype wire

>>> sv/b64d_core.sv
`default_nettype none
module b64d_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       in_char,
	input  wire logic             end_of_text,
	output logic                  pending,
	output logic                  push,
	output b64d_pkg::group_t      grp
);
	import b64d_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;

	logic [1:0]  phase_q, phase_d;
	logic [17:0] held_q, held_d;
	status_t     err_q, err_d;
	logic        pad_q, pad_d;

	logic [6:0]  sym;
	logic        is_break;
	logic        is_bad;
	logic [5:0]  s0, s1, s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= in_char;
			eot_s1  <= end_of_text;
		end
	end

	assign sym      = classify(char_s1);
	assign is_break = (char_s1 == CHAR_CR) || (char_s1 == CHAR_LF);
	assign is_bad   = (sym == SYM_BAD) || (sym == SYM_PAD && phase_q < 2'd2);
	assign s0       = held_q[17:12];
	assign s1       = held_q[11:6];
	assign s2       = held_q[5:0];

	always_comb begin
		phase_d     = phase_q;
		held_d      = held_q;
		err_d       = err_q;
		pad_d       = pad_q;
		grp.cnt     = 2'd0;
		grp.bytes   = '0;
		grp.status  = ST_DATA;
		if (valid_s1) begin
			if (eot_s1) begin
				grp.cnt = 2'd1;
				if (err_q != ST_DATA) begin
					grp.status = err_q;
				end else if (phase_q != 2'd0) begin
					grp.status = ST_BADLEN;
				end else begin
					grp.status = ST_DONE;
				end
				phase_d = 2'd0;
				held_d  = '0;
				err_d   = ST_DATA;
				pad_d   = 1'b0;
			end else if (!is_break && err_q == ST_DATA) begin
				if (is_bad) begin
					err_d = ST_BADCHAR;
				end else begin
					unique case (phase_q)
						2'd0, 2'd1: begin
							held_d  = {held_q[11:0], sym[5:0]};
							phase_d = phase_q + 2'd1;
						end
						2'd2: begin
							// pad here holds a zero sextet
							if (sym == SYM_PAD) begin
								held_d = {held_q[11:0], 6'd0};
								pad_d  = 1'b1;
							end else begin
								held_d = {held_q[11:0], sym[5:0]};
							end
							phase_d = 2'd3;
						end
						default: begin
							grp.bytes[0] = {s0, s1[5:4]};
							grp.bytes[1] = {s1[3:0], s2[5:2]};
							grp.bytes[2] = {s2[1:0], sym[5:0]};
							if (pad_q) begin
								grp.cnt = 2'd1;
							end else if (sym == SYM_PAD) begin
								grp.cnt = 2'd2;
							end else begin
								grp.cnt = 2'd3;
							end
							phase_d = 2'd0;
							held_d  = '0;
							pad_d   = 1'b0;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			held_q  <= '0;
			err_q   <= ST_DATA;
			pad_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
			err_q   <= err_d;
			pad_q   <= pad_d;
		end
	end

	assign pending = valid_s1;
	assign push    = grp.cnt != 2'd0;

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eot_s1 |=> phase_q == 2'd0 && err_q == ST_DATA && !pad_q)
		else $error("terminator did not clear decoder state");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		err_q == ST_DATA || err_q == ST_BADCHAR)
		else $error("unexpected error code held");

	a_pad_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> phase_q == 2'd3)
		else $error("pad flag set outside last quartet position");

	a_push_source: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> valid_s1 && (eot_s1 || phase_q == 2'd3))
		else $error("results produced without terminator or full quartet");
endmodule
`default_nettype wire

>>> sv/b64d_outq.sv
`default_nettype none
module b64d_outq #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64d_pkg::group_t grp,
	input  wire logic             pending,
	output logic                  full_soon,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            out_byte,
	output logic [1:0]            status,
	output logic                  last
);
	import b64d_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t             fifo_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         sub_q;

	logic               out_valid_q;
	logic [7:0]         byte_q;
	status_t            status_q;
	logic               last_q;

	group_t             head;
	logic               head_last;
	logic               load;
	logic               pop;

	assign head      = fifo_q[rd_ptr_q];
	assign head_last = sub_q == (head.cnt - 2'd1);
	assign load      = (count_q != '0) && (!out_valid_q || !out_stall);
	assign pop       = load && head_last;

	// counts the item sitting in the input register, which may still push
	assign full_soon = ({1'b0, count_q} + {{CNT_W{1'b0}}, pending}) >= (CNT_W + 1)'(DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
			if (load) begin
				sub_q <= head_last ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= count_q != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= head.bytes[sub_q];
			status_q <= head.status;
			last_q   <= head_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign status    = status_q;
	assign last      = last_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < CNT_W'(DEPTH) || pop)
		else $error("result queue overflow");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> sub_q < head.cnt)
		else $error("byte index beyond group size");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DATA |-> last_q && byte_q == 8'd0)
		else $error("status item not marked last or carries data");
endmodule
`default_nettype wire

>>> sv/base64_stream_decoder.sv
`default_nettype none
// Base64 (standard alphabet) stream decoder. One text character per item; CR and LF are
// skipped. The fourth character of a quartet releases one to three bytes (fewer on '=' padding),
// and an end_of_text item releases a single status result (done, bad character or bad length)
// and returns the decoder to its reset state. After a bad character nothing is emitted until the
// terminator. Items are accepted one per cycle while in_stall is low: an input register feeds the
// decode logic, which writes each item's results as one group into a FIFO_DEPTH-entry queue; an
// output register sends them one per cycle while out_stall is low. A completed quartet yields at
// most three bytes for its four characters, so in_stall rises only when the queue fills behind a
// stalled or slower consumer. Results pass the input register, queue and output register in turn.
module base64_stream_decoder #(
	parameter int FIFO_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      status,
	output logic            last
);
	import b64d_pkg::*;

	logic   accept;
	logic   pending;
	logic   push;
	logic   full_soon;
	group_t grp;

	assign in_stall = full_soon;
	assign accept   = in_valid && !in_stall;

	b64d_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_char     (in_char),
		.end_of_text (end_of_text),
		.pending     (pending),
		.push        (push),
		.grp         (grp)
	);

	b64d_outq #(
		.DEPTH (FIFO_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.grp       (grp),
		.pending   (pending),
		.full_soon (full_soon),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);
endmodule
`default_nettype wire
